// ===== rtl/core/swcf_pkg.sv =====
// Shared types, constants and step functions of the shallow-water flux pipeline.
package swcf_pkg;

  // Quotient and root bits produced by the iterative units.
  localparam int QBITS           = 32;
  // Iteration steps carried out in one pipeline stage by default.
  localparam int STEPS_PER_STAGE = 4;
  // Parallel divider lanes.
  localparam int NUM_LANES       = 5;
  localparam int LANE_UU         = 0;
  localparam int LANE_UV         = 1;
  localparam int LANE_VV         = 2;
  localparam int LANE_VX         = 3;
  localparam int LANE_VY         = 4;

  // Gravity in Q16.16, rounded to nearest.
  localparam logic [19:0] G_FULL_Q16 = 20'd642253;
  localparam logic [18:0] G_HALF_Q16 = 19'd321126;
  // Cap on the scaled squared depth.
  localparam logic [40:0] T_CAP      = {1'b1, 40'd0};
  localparam logic [15:0] EPS_RESET  = 16'd1;

  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic [30:0] U31_MAX = 31'h7fff_ffff;

  typedef struct packed {
    logic [QBITS-1:0] rem;
    logic [QBITS-1:0] lq;
    logic             ovf;
    logic             nz;
  } div_t;

  typedef struct packed {
    logic [QBITS+2:0] rem;
    logic [QBITS-1:0] root;
    logic [63:0]      v;
  } sqrt_t;

  typedef struct packed {
    logic [30:0]        h;
    logic [31:0]        d;
    logic signed [31:0] hu;
    logic signed [31:0] hv;
    logic               neg;
    logic               uv_neg;
    logic [40:0]        tcap;
  } side_t;

  typedef struct packed {
    side_t                  side;
    div_t [NUM_LANES-1:0]   lane;
    sqrt_t                  sq;
  } pipe_t;

  typedef struct packed {
    logic [31:0] depth_used;
    logic [31:0] flux_x_mass;
    logic [31:0] flux_x_mom_x;
    logic [31:0] flux_x_mom_y;
    logic [31:0] flux_y_mass;
    logic [31:0] flux_y_mom_x;
    logic [31:0] flux_y_mom_y;
    logic [30:0] wave_speed_x;
    logic [30:0] wave_speed_y;
    logic        depth_was_negative;
  } res_t;

  // One restoring division step: bring down the next numerator bit.
  function automatic div_t div_step(div_t s, logic [QBITS-1:0] den);
    div_t         r;
    logic [QBITS:0] trial;
    r     = s;
    trial = {s.rem, s.lq[QBITS-1]};
    if (trial >= {1'b0, den}) begin
      r.rem = QBITS'(trial - {1'b0, den});
      r.lq  = {s.lq[QBITS-2:0], 1'b1};
    end else begin
      r.rem = trial[QBITS-1:0];
      r.lq  = {s.lq[QBITS-2:0], 1'b0};
    end
    return r;
  endfunction

  // One digit-by-digit square root step on the next bit pair.
  function automatic sqrt_t sqrt_step(sqrt_t s);
    sqrt_t          r;
    logic [QBITS+2:0] acc;
    logic [QBITS+2:0] trial;
    acc   = {s.rem[QBITS:0], s.v[63:62]};
    trial = {1'b0, s.root, 2'b01};
    r.v   = {s.v[61:0], 2'b00};
    if (acc >= trial) begin
      r.rem  = acc - trial;
      r.root = {s.root[QBITS-2:0], 1'b1};
    end else begin
      r.rem  = acc;
      r.root = {s.root[QBITS-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/swcf_ifs.sv =====
// Channel interfaces: cell input, flux result and epsilon write.
interface swcf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] depth;
  logic signed [31:0] momentum_x;
  logic signed [31:0] momentum_y;
  modport source (output valid, depth, momentum_x, momentum_y, input ready);
  modport sink   (input valid, depth, momentum_x, momentum_y, output ready);
endinterface

interface swcf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] depth_used;
  logic signed [31:0] flux_x_mass;
  logic signed [31:0] flux_x_mom_x;
  logic signed [31:0] flux_x_mom_y;
  logic signed [31:0] flux_y_mass;
  logic signed [31:0] flux_y_mom_x;
  logic signed [31:0] flux_y_mom_y;
  logic [30:0]        wave_speed_x;
  logic [30:0]        wave_speed_y;
  logic               depth_was_negative;
  modport source (output valid, depth_used, flux_x_mass, flux_x_mom_x, flux_x_mom_y,
                  flux_y_mass, flux_y_mom_x, flux_y_mom_y, wave_speed_x, wave_speed_y,
                  depth_was_negative, input ready);
  modport sink   (input valid, depth_used, flux_x_mass, flux_x_mom_x, flux_x_mom_y,
                  flux_y_mass, flux_y_mom_x, flux_y_mom_y, wave_speed_x, wave_speed_y,
                  depth_was_negative, output ready);
endinterface

interface swcf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/swcf_front.sv =====
// Front stages: depth clamp, products and divider/root setup.
module swcf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [31:0]  depth,
  input  logic signed [31:0]  momentum_x,
  input  logic signed [31:0]  momentum_y,
  input  logic [15:0]         eps,
  output logic                out_valid,
  output swcf_pkg::pipe_t     out_data
);
  import swcf_pkg::*;

  logic               v1, v2;
  logic [30:0]        h1, h2;
  logic [31:0]        d1, d2;
  logic               neg1, neg2;
  logic signed [31:0] hu1, hv1, hu2, hv2;
  logic [63:0]        uu2, uv2, vv2;
  logic [61:0]        hh2;
  logic [50:0]        hg2;
  logic [31:0]        absu2, absv2;
  logic               uvneg2;

  logic [30:0]        h_clamp;
  logic [31:0]        abs_u, abs_v;
  logic [63:0]        p_uu, p_uv, p_vv;
  logic [61:0]        p_hh;
  logic [50:0]        p_hg;
  logic [45:0]        t_full;
  logic [63:0]        num [NUM_LANES];
  pipe_t              stage_next;

  // Stage 1: replace a negative depth by epsilon and form h + eps.
  assign h_clamp = depth[31] ? {15'd0, eps} : depth[30:0];

  // Stage 2: magnitudes and the five products.
  assign abs_u = hu1[31] ? (~hu1 + 32'd1) : hu1;
  assign abs_v = hv1[31] ? (~hv1 + 32'd1) : hv1;
  assign p_uu  = abs_u * abs_u;
  assign p_uv  = abs_u * abs_v;
  assign p_vv  = abs_v * abs_v;
  assign p_hh  = h1 * h1;
  assign p_hg  = h1 * G_FULL_Q16;

  // Stage 3: cap the gravity operand and load the dividers and the root unit.
  assign t_full = hh2[61:16];
  always_comb begin
    num[LANE_UU] = uu2;
    num[LANE_UV] = uv2;
    num[LANE_VV] = vv2;
    num[LANE_VX] = {16'd0, absu2, 16'd0};
    num[LANE_VY] = {16'd0, absv2, 16'd0};
    stage_next.side.h      = h2;
    stage_next.side.d      = d2;
    stage_next.side.hu     = hu2;
    stage_next.side.hv     = hv2;
    stage_next.side.neg    = neg2;
    stage_next.side.uv_neg = uvneg2;
    stage_next.side.tcap   = (t_full > {5'd0, T_CAP}) ? T_CAP : t_full[40:0];
    for (int k = 0; k < NUM_LANES; k++) begin
      stage_next.lane[k].rem = num[k][63:32];
      stage_next.lane[k].lq  = num[k][31:0];
      stage_next.lane[k].nz  = (num[k] != 64'd0);
      stage_next.lane[k].ovf = (num[k] != 64'd0) && (num[k][63:32] >= d2);
    end
    stage_next.sq.rem  = '0;
    stage_next.sq.root = '0;
    stage_next.sq.v    = {13'd0, hg2};
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Payload registers of the three stages.
  always_ff @(posedge clk) begin
    if (en) begin
      h1       <= h_clamp;
      d1       <= {1'b0, h_clamp} + {16'd0, eps};
      neg1     <= depth[31];
      hu1      <= momentum_x;
      hv1      <= momentum_y;
      h2       <= h1;
      d2       <= d1;
      neg2     <= neg1;
      hu2      <= hu1;
      hv2      <= hv1;
      uu2      <= p_uu;
      uv2      <= p_uv;
      vv2      <= p_vv;
      hh2      <= p_hh;
      hg2      <= p_hg;
      absu2    <= abs_u;
      absv2    <= abs_v;
      uvneg2   <= hu1[31] ^ hv1[31];
      out_data <= stage_next;
    end
  end

endmodule

// ===== rtl/core/swcf_div_stage.sv =====
// One iteration stage: STEPS steps of all divider lanes and the square root.
module swcf_div_stage #(
  parameter int STEPS = swcf_pkg::STEPS_PER_STAGE
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  swcf_pkg::pipe_t in_data,
  output logic            out_valid,
  output swcf_pkg::pipe_t out_data
);
  import swcf_pkg::*;

  pipe_t stage_next;

  // Advance every divider lane and the square root by STEPS bits, the lanes sharing the denominator.
  always_comb begin
    stage_next = in_data;
    for (int i = 0; i < STEPS; i++) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        stage_next.lane[k] = div_step(stage_next.lane[k], stage_next.side.d);
      end
      stage_next.sq = sqrt_step(stage_next.sq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= stage_next;
    end
  end

endmodule

// ===== rtl/core/swcf_back.sv =====
// Back stages: gravity term, sums and saturation into the result register.
module swcf_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  swcf_pkg::pipe_t in_data,
  output logic            out_valid,
  output swcf_pkg::res_t  out_data
);
  import swcf_pkg::*;

  logic        v_b1;
  pipe_t       p_b1;
  logic [43:0] grav_b1;
  logic [59:0] gprod;
  logic [31:0] q [NUM_LANES];
  logic [44:0] sum_xx, sum_yy;
  logic [32:0] sum_sx, sum_sy;
  logic [31:0] cross_term;
  res_t        res_next;

  // First stage: gravity product g/2 * t.
  assign gprod = in_data.side.tcap * G_HALF_Q16;

  // Second stage: quotients, sums and clipping.
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      q[k] = p_b1.lane[k].nz ? p_b1.lane[k].lq : 32'd0;
    end
    sum_xx = {13'd0, q[LANE_UU]} + {1'b0, grav_b1};
    sum_yy = {13'd0, q[LANE_VV]} + {1'b0, grav_b1};
    sum_sx = {1'b0, q[LANE_VX]} + {1'b0, p_b1.sq.root};
    sum_sy = {1'b0, q[LANE_VY]} + {1'b0, p_b1.sq.root};

    // Signed cross term from its magnitude.
    if (p_b1.lane[LANE_UV].ovf) begin
      cross_term = p_b1.side.uv_neg ? S32_MIN : S32_MAX;
    end else if (!p_b1.side.uv_neg) begin
      cross_term = q[LANE_UV][31] ? S32_MAX : q[LANE_UV];
    end else begin
      cross_term = (q[LANE_UV] > S32_MIN) ? S32_MIN : (~q[LANE_UV] + 32'd1);
    end

    res_next.depth_used   = {1'b0, p_b1.side.h};
    res_next.flux_x_mass  = p_b1.side.hu;
    res_next.flux_y_mass  = p_b1.side.hv;
    res_next.flux_x_mom_y = cross_term;
    res_next.flux_y_mom_x = cross_term;
    res_next.flux_x_mom_x = (p_b1.lane[LANE_UU].ovf || sum_xx > {13'd0, S32_MAX})
                            ? S32_MAX : sum_xx[31:0];
    res_next.flux_y_mom_y = (p_b1.lane[LANE_VV].ovf || sum_yy > {13'd0, S32_MAX})
                            ? S32_MAX : sum_yy[31:0];
    res_next.wave_speed_x = (p_b1.lane[LANE_VX].ovf || sum_sx > {2'd0, U31_MAX})
                            ? U31_MAX : sum_sx[30:0];
    res_next.wave_speed_y = (p_b1.lane[LANE_VY].ovf || sum_sy > {2'd0, U31_MAX})
                            ? U31_MAX : sum_sy[30:0];
    res_next.depth_was_negative = p_b1.side.neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b1      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_b1      <= in_valid;
      out_valid <= v_b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_b1     <= in_data;
      grav_b1  <= gprod[59:16];
      out_data <= res_next;
    end
  end

endmodule

// ===== rtl/core/shallow_water_cell_flux_top.sv =====
// Top level of the shallow-water cell flux pipeline.
// Path from input transfer to result: the front stages, the iteration stages and the back stages.
// Throughput: one cell per cycle; the whole pipeline holds while the result is not taken.
// The depth set by the 32 quotient and root bits, STEPS_PER_STAGE of them per stage.
// Reset (synchronous, active high) empties every stage and sets epsilon to 1.
module shallow_water_cell_flux_top #(
  parameter int STEPS_PER_STAGE = swcf_pkg::STEPS_PER_STAGE
) (
  input  logic       clk,
  input  logic       rst,
  swcf_in_if.sink    cell_data,
  swcf_out_if.source flux,
  swcf_cfg_if.sink   cfg
);
  import swcf_pkg::*;

  localparam int NUM_STAGES = QBITS / STEPS_PER_STAGE;

  logic                  en;
  logic [15:0]           depth_epsilon;
  logic [NUM_STAGES:0]   stage_valid;
  pipe_t                 stage_data [NUM_STAGES+1];
  logic                  res_valid;
  res_t                  res;

  // The pipeline moves whenever the result register is free or being taken.
  assign en              = !res_valid || flux.ready;
  assign cell_data.ready = en;
  assign cfg.ready       = 1'b1;

  // Epsilon register.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_epsilon <= EPS_RESET;
    end else if (cfg.valid) begin
      depth_epsilon <= cfg.data;
    end
  end

  swcf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (cell_data.valid),
    .depth      (cell_data.depth),
    .momentum_x (cell_data.momentum_x),
    .momentum_y (cell_data.momentum_y),
    .eps        (depth_epsilon),
    .out_valid  (stage_valid[0]),
    .out_data   (stage_data[0])
  );

  // Chain of iteration stages.
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    swcf_div_stage #(.STEPS(STEPS_PER_STAGE)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (stage_valid[s]),
      .in_data   (stage_data[s]),
      .out_valid (stage_valid[s+1]),
      .out_data  (stage_data[s+1])
    );
  end

  swcf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (stage_valid[NUM_STAGES]),
    .in_data   (stage_data[NUM_STAGES]),
    .out_valid (res_valid),
    .out_data  (res)
  );

  // Result channel.
  assign flux.valid              = res_valid;
  assign flux.depth_used         = res.depth_used;
  assign flux.flux_x_mass        = res.flux_x_mass;
  assign flux.flux_x_mom_x       = res.flux_x_mom_x;
  assign flux.flux_x_mom_y       = res.flux_x_mom_y;
  assign flux.flux_y_mass        = res.flux_y_mass;
  assign flux.flux_y_mom_x       = res.flux_y_mom_x;
  assign flux.flux_y_mom_y       = res.flux_y_mom_y;
  assign flux.wave_speed_x       = res.wave_speed_x;
  assign flux.wave_speed_y       = res.wave_speed_y;
  assign flux.depth_was_negative = res.depth_was_negative;

  // A clamped depth is epsilon, which fits in the fraction bits.
  a_clamp_small: assert property (@(posedge clk) disable iff (rst)
    flux.valid && flux.depth_was_negative |-> flux.depth_used[31:16] == 16'd0)
    else $error("clamped depth exceeds epsilon range");

  // The used depth and the x-x and y-y momentum fluxes are never negative.
  a_nonneg: assert property (@(posedge clk) disable iff (rst)
    flux.valid |-> !flux.depth_used[31] && !flux.flux_x_mom_x[31] && !flux.flux_y_mom_y[31])
    else $error("negative depth or momentum flux");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !flux.valid)
    else $error("result valid right after reset");

endmodule
